// ----- sv/date_time_normalizer_top_assert.svh -----
// Assertion macros shared by the date/time normalizer checker.
`ifndef DATE_TIME_NORMALIZER_TOP_ASSERT_SVH
`define DATE_TIME_NORMALIZER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DTN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DTN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/dtn_pkg.sv -----
// Shared types, constants and helper functions of the date/time normalizer.
package dtn_pkg;

    // Reciprocal division: q = (a * M) >> RECIP_SHIFT, exact for a < 2^18.
    localparam int RECIP_SHIFT = 24;
    localparam int OPND_W      = 18;
    localparam int RECIP_W     = 21;
    localparam int QUOT_W      = 12;

    localparam logic [RECIP_W-1:0] RECIP_60 = 21'd279621;
    localparam logic [RECIP_W-1:0] RECIP_24 = 21'd699051;
    localparam logic [RECIP_W-1:0] RECIP_12 = 21'd1398102;
    localparam logic [RECIP_W-1:0] RECIP_25 = 21'd671089;

    // Offsets that make each dividend non-negative; each is a multiple of its divisor, but MON_OFS is one less.
    localparam logic [OPND_W-1:0] MIN_OFS  = 18'd65580;   // 60 * 1093
    localparam logic [OPND_W-1:0] HOUR_OFS = 18'd5208;    // 24 * 217
    localparam logic [OPND_W-1:0] MON_OFS  = 18'd4103;    // 12 * 342, less one for month base
    localparam logic [OPND_W-1:0] YEAR_OFS = 18'd16750;   // 25 * 670

    localparam logic [13:0] MIN_QBIAS  = 14'd1093;
    localparam logic [13:0] HOUR_QBIAS = 14'd217;
    localparam logic [15:0] MON_QBIAS  = 16'd342;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [4:0] MOD25_MAX = 5'd24;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIV_MIN,
        OP_FIX_MIN,
        OP_DIV_HOUR,
        OP_FIX_HOUR,
        OP_DIV_MON,
        OP_FIX_MON,
        OP_DIV_YEAR,
        OP_FIX_YEAR,
        OP_FOLD
    } dtn_op_t;

    typedef struct packed {
        logic    load;
        logic    store;
        dtn_op_t op;
    } dtn_cmd_t;

    typedef struct packed {
        logic fold_done;
    } dtn_stat_t;

    function automatic logic [QUOT_W-1:0] recip_quot(input logic [OPND_W-1:0] a,
                                                     input logic [RECIP_W-1:0] m);
        logic [OPND_W+RECIP_W-1:0] prod;
        prod = {{RECIP_W{1'b0}}, a} * {{OPND_W{1'b0}}, m};
        return prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- sv/dtn_datapath.sv -----
// Datapath: field registers, reciprocal divider, month fold and result register.
module dtn_datapath
    import dtn_pkg::*;
(
    input  logic                clk,
    input  dtn_cmd_t            cmd,
    output dtn_stat_t           stat,
    input  logic signed [14:0]  year_in,
    input  logic signed [12:0]  month_in,
    input  logic signed [12:0]  day_in,
    input  logic signed [12:0]  hour_in,
    input  logic signed [16:0]  minute_in,
    output logic signed [15:0]  year_out,
    output logic        [3:0]   month_out,
    output logic        [4:0]   day_out,
    output logic        [4:0]   hour_out,
    output logic        [5:0]   minute_out
);

    logic [15:0] year_reg;
    logic [12:0] mon_reg;
    logic [13:0] day_reg;
    logic [13:0] hour_reg;
    logic [16:0] min_reg;
    logic [4:0]  y25_reg;
    logic [QUOT_W-1:0] q_reg;

    logic [15:0] year_out_reg;
    logic [3:0]  month_out_reg;
    logic [4:0]  day_out_reg;
    logic [4:0]  hour_out_reg;
    logic [5:0]  minute_out_reg;

    logic [OPND_W-1:0]  opnd;
    logic [RECIP_W-1:0] recip;
    logic [5:0]         divisor;
    logic [OPND_W-1:0]  rem;
    logic [OPND_W-1:0]  q_times_d;

    logic [3:0]  mon;
    logic [3:0]  prev_mon;
    logic        leap;
    logic [4:0]  len_cur;
    logic [4:0]  len_prev;
    logic        step_fwd;
    logic        step_back;

    // dividend and divisor selection, same for both phases of one division
    always_comb
    begin
        opnd    = '0;
        recip   = RECIP_60;
        divisor = 6'd60;
        unique case (cmd.op)
            OP_DIV_MIN, OP_FIX_MIN:
            begin
                opnd    = {min_reg[16], min_reg} + MIN_OFS;
                recip   = RECIP_60;
                divisor = 6'd60;
            end
            OP_DIV_HOUR, OP_FIX_HOUR:
            begin
                opnd    = {{4{hour_reg[13]}}, hour_reg} + HOUR_OFS;
                recip   = RECIP_24;
                divisor = 6'd24;
            end
            OP_DIV_MON, OP_FIX_MON:
            begin
                opnd    = {{5{mon_reg[12]}}, mon_reg} + MON_OFS;
                recip   = RECIP_12;
                divisor = 6'd12;
            end
            OP_DIV_YEAR, OP_FIX_YEAR:
            begin
                opnd    = {{2{year_reg[15]}}, year_reg} + YEAR_OFS;
                recip   = RECIP_25;
                divisor = 6'd25;
            end
            default:
            begin
                opnd    = '0;
            end
        endcase
    end

    assign q_times_d = {{(OPND_W-QUOT_W){1'b0}}, q_reg} * {{(OPND_W-6){1'b0}}, divisor};
    assign rem       = opnd - q_times_d;

    // month fold; Feb only matters in the current year, Jan's predecessor is Dec
    assign mon       = mon_reg[3:0];
    assign prev_mon  = (mon == MONTH_JAN) ? MONTH_DEC : mon - 4'd1;
    assign leap      = (year_reg[1:0] == 2'b00) && ((y25_reg != 5'd0) || (year_reg[3:0] == 4'd0));
    assign len_cur   = month_len(mon, leap);
    assign len_prev  = month_len(prev_mon, leap);
    assign step_fwd  = $signed(day_reg) > $signed({9'b0, len_cur});
    assign step_back = day_reg[13] || (day_reg == 14'd0);

    assign stat.fold_done = !step_fwd && !step_back;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            year_reg <= {year_in[14], year_in};
            mon_reg  <= month_in;
            day_reg  <= {day_in[12], day_in};
            hour_reg <= {hour_in[12], hour_in};
            min_reg  <= minute_in;
        end
        else
        begin
            unique case (cmd.op)
                OP_DIV_MIN, OP_DIV_HOUR, OP_DIV_MON, OP_DIV_YEAR:
                begin
                    q_reg <= recip_quot(opnd, recip);
                end
                OP_FIX_MIN:
                begin
                    min_reg  <= rem[16:0];
                    hour_reg <= hour_reg + {2'b0, q_reg} - MIN_QBIAS;
                end
                OP_FIX_HOUR:
                begin
                    hour_reg <= rem[13:0];
                    day_reg  <= day_reg + {2'b0, q_reg} - HOUR_QBIAS;
                end
                OP_FIX_MON:
                begin
                    mon_reg  <= rem[12:0] + 13'd1;
                    year_reg <= year_reg + {4'b0, q_reg} - MON_QBIAS;
                end
                OP_FIX_YEAR:
                begin
                    y25_reg <= rem[4:0];
                end
                OP_FOLD:
                begin
                    if (step_fwd)
                    begin
                        day_reg <= day_reg - {9'b0, len_cur};
                        if (mon == MONTH_DEC)
                        begin
                            mon_reg  <= {9'b0, MONTH_JAN};
                            year_reg <= year_reg + 16'd1;
                            y25_reg  <= (y25_reg == MOD25_MAX) ? 5'd0 : y25_reg + 5'd1;
                        end
                        else
                        begin
                            mon_reg <= {9'b0, mon + 4'd1};
                        end
                    end
                    else if (step_back)
                    begin
                        day_reg <= day_reg + {9'b0, len_prev};
                        mon_reg <= {9'b0, prev_mon};
                        if (mon == MONTH_JAN)
                        begin
                            year_reg <= year_reg - 16'd1;
                            y25_reg  <= (y25_reg == 5'd0) ? MOD25_MAX : y25_reg - 5'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.store)
        begin
            year_out_reg   <= year_reg;
            month_out_reg  <= mon;
            day_out_reg    <= day_reg[4:0];
            hour_out_reg   <= hour_reg[4:0];
            minute_out_reg <= min_reg[5:0];
        end
    end

    assign year_out   = $signed(year_out_reg);
    assign month_out  = month_out_reg;
    assign day_out    = day_out_reg;
    assign hour_out   = hour_out_reg;
    assign minute_out = minute_out_reg;

endmodule

// ----- sv/dtn_ctrl.sv -----
// Controller: sequences the carries, the month fold and the output handshake.
module dtn_ctrl
    import dtn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output dtn_cmd_t  cmd,
    input  dtn_stat_t stat
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_MIN,
        ST_FIX_MIN,
        ST_DIV_HOUR,
        ST_FIX_HOUR,
        ST_DIV_MON,
        ST_FIX_MON,
        ST_DIV_YEAR,
        ST_FIX_YEAR,
        ST_FOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   store;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign store     = (state_reg == ST_FOLD) && stat.fold_done && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd.load  = in_valid && (state_reg == ST_IDLE);
        cmd.store = store;
        unique case (state_reg)
            ST_DIV_MIN:  cmd.op = OP_DIV_MIN;
            ST_FIX_MIN:  cmd.op = OP_FIX_MIN;
            ST_DIV_HOUR: cmd.op = OP_DIV_HOUR;
            ST_FIX_HOUR: cmd.op = OP_FIX_HOUR;
            ST_DIV_MON:  cmd.op = OP_DIV_MON;
            ST_FIX_MON:  cmd.op = OP_FIX_MON;
            ST_DIV_YEAR: cmd.op = OP_DIV_YEAR;
            ST_FIX_YEAR: cmd.op = OP_FIX_YEAR;
            ST_FOLD:     cmd.op = OP_FOLD;
            default:     cmd.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:     state_next = in_valid ? ST_DIV_MIN : ST_IDLE;
            ST_DIV_MIN:  state_next = ST_FIX_MIN;
            ST_FIX_MIN:  state_next = ST_DIV_HOUR;
            ST_DIV_HOUR: state_next = ST_FIX_HOUR;
            ST_FIX_HOUR: state_next = ST_DIV_MON;
            ST_DIV_MON:  state_next = ST_FIX_MON;
            ST_FIX_MON:  state_next = ST_DIV_YEAR;
            ST_DIV_YEAR: state_next = ST_FIX_YEAR;
            ST_FIX_YEAR: state_next = ST_FOLD;
            ST_FOLD:     state_next = store ? ST_IDLE : ST_FOLD;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (store)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- sv/date_time_normalizer_top.sv -----
// Each beat runs the minute, hour and month carries and the year mod-25 step, then the month fold over
// N months (N = 0..~143); the fold loop steps one month per cycle until the day fits its month.
// Input is taken only in idle; a finished result waits in the output register meanwhile.
// Reset (rst_n, async, active low) clears the controller state and the output valid.
// Payload registers are not reset; no state carries from one beat to the next.
// Carries use constant-reciprocal multiplies: the quotient first, then the remainder.
module date_time_normalizer_top
    import dtn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // year_in[14:0], month_in[27:15], day_in[40:28],
                                   // hour_in[53:41], minute_in[70:54], pad[71]
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // year_out[15:0], month_out[19:16], day_out[24:20],
                                   // hour_out[29:25], minute_out[35:30], zero pad[39:36]
);

    dtn_cmd_t  cmd;
    dtn_stat_t stat;

    logic signed [15:0] year_out;
    logic        [3:0]  month_out;
    logic        [4:0]  day_out;
    logic        [4:0]  hour_out;
    logic        [5:0]  minute_out;

    // control: step sequence, fold termination, output valid
    dtn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath: fields unpacked straight from the input beat
    dtn_datapath u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .stat       (stat),
        .year_in    ($signed(s_tdata[14:0])),
        .month_in   ($signed(s_tdata[27:15])),
        .day_in     ($signed(s_tdata[40:28])),
        .hour_in    ($signed(s_tdata[53:41])),
        .minute_in  ($signed(s_tdata[70:54])),
        .year_out   (year_out),
        .month_out  (month_out),
        .day_out    (day_out),
        .hour_out   (hour_out),
        .minute_out (minute_out)
    );

    assign m_tdata = {4'b0, minute_out, hour_out, day_out, month_out, year_out};

endmodule

// ----- sv/dtn_checker.sv -----
// Port-level checker for the date/time normalizer, bound to the top level.
`include "date_time_normalizer_top_assert.svh"

module dtn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    logic [3:0] mon;
    logic [4:0] day;

    assign mon = m_tdata[19:16];
    assign day = m_tdata[24:20];

    // stalled result beat holds
    `DTN_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat dropped or changed while stalled")
    // fields in range, pad zero
    `DTN_ASSERT_SAME(a_out_range, m_tvalid, (mon != 4'd0) && (mon <= 4'd12) && (day != 5'd0) && (m_tdata[29:25] <= 5'd23) && (m_tdata[35:30] <= 6'd59) && (m_tdata[39:36] == 4'd0), "result field out of range")
    // day fits the month
    `DTN_ASSERT_SAME(a_day_fits, m_tvalid, ((mon != 4'd2) || (day <= 5'd29)) && ((mon != 4'd4 && mon != 4'd6 && mon != 4'd9 && mon != 4'd11) || (day <= 5'd30)), "day beyond month length")
    // one item at a time
    `DTN_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "input taken while busy")
    // no result the cycle right after an accept into an empty output
    `DTN_ASSERT_NEXT(a_min_latency, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result appeared too early")

endmodule

bind date_time_normalizer_top dtn_checker u_dtn_checker (.*);

// ----- dv/dtn_result_checker.sv -----
// Checker for the date/time normalizer: predicts each result beat and compares it.
`timescale 1ns / 100ps

module dtn_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // year_in[14:0], month_in[27:15], day_in[40:28],
                                   // hour_in[53:41], minute_in[70:54], pad[71]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // year_out[15:0], month_out[19:16], day_out[24:20],
                                   // hour_out[29:25], minute_out[35:30], pad[39:36]
    output int          fail_count,
    output int          pending
);

    localparam int MIN_PER_HOUR = 60;
    localparam int HOUR_PER_DAY = 24;
    localparam int MON_PER_YEAR = 12;

    // Packed to match m_tdata, year in the low bits.
    typedef struct packed {
        logic [3:0]  pad;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
    } dtn_result_t;

    dtn_result_t expected_dates[$];

    // Quotient rounded toward minus infinity, remainder in [0, den).
    function automatic int floor_div(input int num, input int den, output int rem);
        int q;
        int r;
        q = num / den;
        r = num % den;
        if (r < 0) begin
            r = r + den;
            q = q - 1;
        end
        rem = r;
        return q;
    endfunction

    // Leap rule applied to the signed year as is: 0, -4, -400 leap; -100 not.
    function automatic bit is_leap_year(input int yr);
        return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
    endfunction

    function automatic int month_days(input int yr, input int mon);
        case (mon)
            2:          return is_leap_year(yr) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    function automatic dtn_result_t normalize_date_time(input logic [71:0] beat);
        int yr;
        int mon;
        int dy;
        int hr;
        int mn;
        int q;
        int r;
        dtn_result_t res;
        yr  = $signed(beat[14:0]);
        mon = $signed(beat[27:15]);
        dy  = $signed(beat[40:28]);
        hr  = $signed(beat[53:41]);
        mn  = $signed(beat[70:54]);
        q  = floor_div(mn, MIN_PER_HOUR, r);
        hr = hr + q;
        mn = r;
        q  = floor_div(hr, HOUR_PER_DAY, r);
        dy = dy + q;
        hr = r;
        q   = floor_div(mon - 1, MON_PER_YEAR, r);
        yr  = yr + q;
        mon = r + 1;
        // fold excess days forward, one month at a time
        while (dy > month_days(yr, mon)) begin
            dy  = dy - month_days(yr, mon);
            mon = mon + 1;
            if (mon > MON_PER_YEAR) begin
                mon = 1;
                yr  = yr + 1;
            end
        end
        // day zero or below borrows the previous month
        while (dy <= 0) begin
            mon = mon - 1;
            if (mon <= 0) begin
                mon = MON_PER_YEAR;
                yr  = yr - 1;
            end
            dy = dy + month_days(yr, mon);
        end
        res.pad    = '0;
        res.year   = yr[15:0];
        res.month  = mon[3:0];
        res.day    = dy[4:0];
        res.hour   = hr[4:0];
        res.minute = mn[5:0];
        return res;
    endfunction

    function automatic int field_mismatch(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk) begin : scoreboard
        dtn_result_t want;
        dtn_result_t got;
        int errs;
        errs = 0;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_dates.size() == 0) begin
                    $error("result beat with nothing expected: %h", m_tdata);
                    errs = errs + 1;
                end else begin
                    want = expected_dates.pop_front();
                    errs = errs + field_mismatch("year_out", int'($signed(want.year)),
                                                 int'($signed(got.year)));
                    errs = errs + field_mismatch("month_out", want.month, got.month);
                    errs = errs + field_mismatch("day_out", want.day, got.day);
                    errs = errs + field_mismatch("hour_out", want.hour, got.hour);
                    errs = errs + field_mismatch("minute_out", want.minute, got.minute);
                    errs = errs + field_mismatch("pad", want.pad, got.pad);
                end
            end
            if (s_tvalid && s_tready)
                expected_dates.push_back(normalize_date_time(s_tdata));
        end
        fail_count <= fail_count + errs;
        pending    <= expected_dates.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top: clock, reset, beat stimulus with random idling, watchdog and verdict.
`timescale 1ns / 100ps

module tb_top;

    // Cycles without any accepted beat before the run is declared hung.
    // Worst case per beat: an idle gap, the carries and the fold, and a result stall.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BEATS   = 1100;
    localparam int MAX_GAP        = 11;
    // Drain after the last result: longest fold plus margin.
    localparam int DRAIN_CYCLES   = 200;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    int fail_count;
    int pending;
    int idle_cycles;

    // Burst flags: while set, that side runs with no idle cycles.
    bit src_burst = 1'b0;
    bit rdy_burst = 1'b0;

    always #10 clk = ~clk;

    date_time_normalizer_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dtn_result_checker u_dtn_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Drive one input beat. The gap comes first so valid is never
    // dropped and raised within the same time step.
    task automatic send_date(input int yr, input int mon, input int dy,
                             input int hr, input int mn);
        int gap;
        gap = src_burst ? 0 : $urandom_range(MAX_GAP, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, mn[16:0], hr[12:0], dy[12:0], mon[12:0], yr[14:0]};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Random field value: nominal or just outside it, some extremes,
    // and half the time a raw bit pattern of the full width.
    function automatic int pick_field(input int width, input int nom_lo, input int nom_hi);
        int lo;
        int hi;
        int raw;
        lo = -(1 << (width - 1));
        hi = (1 << (width - 1)) - 1;
        case ($urandom_range(9, 0))
            0, 1, 2: return nom_lo + int'($urandom_range(nom_hi - nom_lo, 0));
            3: begin
                case ($urandom_range(5, 0))
                    0:       return lo;
                    1:       return hi;
                    2:       return 0;
                    3:       return -1;
                    4:       return nom_lo - 1;
                    default: return nom_hi + 1;
                endcase
            end
            4: return nom_lo - 40 + int'($urandom_range(nom_hi - nom_lo + 80, 0));
            default: begin
                raw = $urandom;
                return (raw <<< (32 - width)) >>> (32 - width);
            end
        endcase
    endfunction

    // Result side: random stall before every beat, with bursts of none.
    initial begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(39, 0) == 0)
                rdy_burst = ~rdy_burst;
            stall = rdy_burst ? 0 : $urandom_range(MAX_GAP, 0);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Watchdog counter: cleared by any accepted beat on either side.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int n;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes and calendar corner cases.
        send_date(0, 0, 0, 0, 0);
        send_date(16383, 4095, 4095, 4095, 65535);          // all max
        send_date(-16384, -4096, -4096, -4096, -65536);     // all min
        send_date(16383, -4096, 4095, -4096, 65535);
        send_date(-16384, 4095, -4096, 4095, -65536);
        send_date(2024, 2, 29, 12, 30);                     // plain leap day
        send_date(2023, 2, 29, 0, 0);                       // not leap: rolls to Mar 1
        send_date(2000, 2, 29, 23, 59);                     // div by 400: leap
        send_date(1900, 2, 29, 0, 0);                       // div by 100: not leap
        send_date(0, 2, 29, 0, 0);                          // year zero is leap
        send_date(-400, 2, 29, 0, 0);
        send_date(-4, 2, 29, 0, 0);
        send_date(-100, 2, 29, 0, 0);                       // negative century: not leap
        send_date(2024, 3, 0, 0, 0);                        // day zero borrows Feb
        send_date(2024, 0, 15, 6, 0);                       // month zero -> Dec prior year
        send_date(2024, 13, 15, 6, 0);                      // month 13 -> Jan next year
        send_date(2000, 1, 1, 0, -1);                       // one minute back over new year
        send_date(1999, 12, 31, 23, 60);                    // one minute forward
        send_date(1999, 12, 32, 0, 0);
        send_date(2001, 1, 1, 24, 0);
        send_date(-1, 1, -59, -25, -61);                    // negative year, all borrows
        send_date(-16384, 1, 1, 0, -1);                     // year below input range
        send_date(16383, 12, 31, 23, 60);                   // year above input range

        // Random part.
        for (n = 0; n < RANDOM_BEATS; n++) begin
            if ($urandom_range(39, 0) == 0)
                src_burst = ~src_burst;
            send_date(pick_field(15, -2000, 3000), pick_field(13, 1, 12),
                      pick_field(13, 1, 31), pick_field(13, 0, 23),
                      pick_field(17, 0, 59));
        end
        s_tvalid <= 1'b0;

        // Let the last acceptance reach the checker, then drain.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
